### rtl/core/replica_ack_quorum_tracker_defines.svh
// Assertion macros shared by the quorum tracker RTL.
`ifndef REPLICA_ACK_QUORUM_TRACKER_DEFINES_SVH
`define REPLICA_ACK_QUORUM_TRACKER_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define RAQT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define RAQT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/raqt_pkg.sv
// Types, constants and compare helpers for the replica ack quorum tracker.
package raqt_pkg;

    localparam int ID_W             = 32;
    localparam int FILE_W           = 32;
    localparam int OFF_W            = 64;
    localparam int QUORUM_W         = 4;
    localparam int QUORUM_MAX       = (1 << QUORUM_W) - 1;
    localparam int MAX_REPLICAS_DEF = 8;
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;

    // Word index of the quorum register on the config port
    localparam logic [ADDR_W-3:0] REG_REQUIRED = '0;

    // Wave that travels down the cell chain, one cell per cycle
    typedef struct packed {
        logic                v;
        logic                first;
        logic [QUORUM_W-1:0] need;
        logic                hit_seen;
        logic                free_seen;
        logic                min_ok;
        logic [ID_W-1:0]     min_id;
        logic [FILE_W-1:0]   min_file;
        logic [OFF_W-1:0]    min_off;
    } scan_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_HIT,
        CMD_FREE,
        CMD_MIN
    } cmd_kind_t;

    // Slot update broadcast to every cell
    typedef struct packed {
        cmd_kind_t       kind;
        logic [ID_W-1:0] min_id;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_UPDATE,
        ST_SCAN2,
        ST_FINISH
    } state_t;

    // Position a is strictly below position b, file compared first
    function automatic logic pos_less(
        input logic [FILE_W-1:0] fa,
        input logic [OFF_W-1:0]  oa,
        input logic [FILE_W-1:0] fb,
        input logic [OFF_W-1:0]  ob
    );
        pos_less = (fa < fb) || ((fa == fb) && (oa < ob));
    endfunction

endpackage

### rtl/core/raqt_cell.sv
// One replica slot of the tracker chain: holds an entry and folds it into the passing wave.
module raqt_cell import raqt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  scan_t             carry_in,
    output scan_t             carry_out,
    input  cmd_t              cmd,
    input  logic [ID_W-1:0]   req_id,
    input  logic [FILE_W-1:0] req_file,
    input  logic [OFF_W-1:0]  req_off
);

    logic              used_reg;
    logic [ID_W-1:0]   id_reg;
    logic [FILE_W-1:0] file_reg;
    logic [OFF_W-1:0]  off_reg;
    logic              hit_reg;
    logic              pick_reg;
    scan_t             out_reg;
    scan_t             out_next;
    logic              is_match;
    logic              take_min;
    logic              wr_en;

    assign is_match = used_reg && (id_reg == req_id);

    // Entry becomes the running minimum: no minimum yet, lower position, or equal position and lower id
    assign take_min = used_reg && (!carry_in.min_ok
                      || pos_less(file_reg, off_reg, carry_in.min_file, carry_in.min_off)
                      || ((file_reg == carry_in.min_file) && (off_reg == carry_in.min_off)
                          && (id_reg < carry_in.min_id)));

    always_comb begin
        out_next = carry_in;
        if (used_reg) begin
            out_next.need = (carry_in.need != '0) ? carry_in.need - QUORUM_W'(1) : '0;
            if (is_match) begin
                out_next.hit_seen = 1'b1;
            end
        end else begin
            out_next.free_seen = 1'b1;
        end
        if (take_min) begin
            out_next.min_ok   = 1'b1;
            out_next.min_id   = id_reg;
            out_next.min_file = file_reg;
            out_next.min_off  = off_reg;
        end
    end

    always_comb begin
        unique case (cmd.kind)
            CMD_NONE: wr_en = 1'b0;
            CMD_HIT:  wr_en = hit_reg;
            CMD_FREE: wr_en = pick_reg;
            CMD_MIN:  wr_en = used_reg && (id_reg == cmd.min_id);
            default:  wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            hit_reg  <= 1'b0;
            pick_reg <= 1'b0;
            out_reg  <= '0;
        end else begin
            out_reg <= out_next;
            // Latch this slot's role while the first wave passes
            if (carry_in.v && carry_in.first) begin
                hit_reg  <= is_match && pos_less(file_reg, off_reg, req_file, req_off);
                pick_reg <= !used_reg && !carry_in.free_seen;
            end
            if (wr_en) begin
                used_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_reg   <= req_id;
            file_reg <= req_file;
            off_reg  <= req_off;
        end
    end

    assign carry_out = out_reg;

endmodule

### rtl/core/replica_ack_quorum_tracker.sv
// Replica ack quorum tracker: sequencer, config register and chain of slot cells.
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+-----------------------------------
//  s_      | s_valid/s_ready, s_replica_id, s_ack_*  | one ack beat per item
//  m_      | m_valid/m_ready, m_release_*            | one result beat per ack
//  apb     | psel/penable/pwrite/paddr/pwdata/prdata | required_replicas at offset 0
//
//  Quorum of one: IDLE goes straight to FINISH and m_valid is registered on leaving FINISH; table untouched.
//  Otherwise the wave crosses the cell chain once to find hit, free slot and minimum,
//  the UPDATE state writes the picked slot, if any, and, when a release check runs, a
//  second wave collects the new minimum.
//  One item is in work at a time; a result waits in FINISH while m_ valid is held.
//  aresetn (synchronous) empties the table and sets the quorum to one.
//  A held result in the output register does not block the next s_ beat.
`include "replica_ack_quorum_tracker_defines.svh"

module replica_ack_quorum_tracker import raqt_pkg::*; #(
    parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ID_W-1:0]   s_replica_id,
    input  logic [FILE_W-1:0] s_ack_file,
    input  logic [OFF_W-1:0]  s_ack_pos,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_release_valid,
    output logic [FILE_W-1:0] m_release_file,
    output logic [OFF_W-1:0]  m_release_pos,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int QCAP = (MAX_REPLICAS < QUORUM_MAX) ? MAX_REPLICAS : QUORUM_MAX;
    localparam logic [QUORUM_W-1:0] QCAP_Q = QUORUM_W'(QCAP);

    state_t              state_reg;
    state_t              state_next;
    logic [QUORUM_W-1:0] required_reg;
    logic [QUORUM_W-1:0] quorum;
    logic [ID_W-1:0]     req_id_reg;
    logic [FILE_W-1:0]   req_file_reg;
    logic [OFF_W-1:0]    req_off_reg;
    scan_t               launch_reg;
    cmd_t                cmd_reg;
    cmd_t                cmd_next;
    logic                go_reg;
    logic                go_next;
    logic                res_valid_reg;
    logic [FILE_W-1:0]   res_file_reg;
    logic [OFF_W-1:0]    res_pos_reg;
    logic                m_valid_reg;
    logic                m_rel_valid_reg;
    logic [FILE_W-1:0]   m_rel_file_reg;
    logic [OFF_W-1:0]    m_rel_pos_reg;
    scan_t               link [MAX_REPLICAS+1];
    scan_t               tail;
    logic                in_beat;
    logic                out_load;
    logic                cfg_wr;
    logic                reg_sel;

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign reg_sel = (paddr[ADDR_W-1:2] == REG_REQUIRED);
    assign cfg_wr  = psel && penable && pwrite && reg_sel;
    assign prdata  = reg_sel ? {(DATA_W-QUORUM_W)'(0), required_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            required_reg <= QUORUM_W'(1);
        end else if (cfg_wr) begin
            required_reg <= pwdata[QUORUM_W-1:0];
        end
    end

    // Zero acts as one, anything above the table size saturates
    always_comb begin
        priority if (required_reg == '0) begin
            quorum = QUORUM_W'(1);
        end else if (required_reg > QCAP_Q) begin
            quorum = QCAP_Q;
        end else begin
            quorum = required_reg;
        end
    end

    // ---------------- cell chain ----------------
    assign link[0] = launch_reg;
    assign tail    = link[MAX_REPLICAS];

    for (genvar i = 0; i < MAX_REPLICAS; i++) begin : g_cell
        raqt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .carry_in (link[i]),
            .carry_out(link[i+1]),
            .cmd      (cmd_reg),
            .req_id   (req_id_reg),
            .req_file (req_file_reg),
            .req_off  (req_off_reg)
        );
    end

    // ---------------- sequencer ----------------
    assign in_beat  = s_valid && s_ready;
    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (quorum == QUORUM_W'(1)) ? ST_FINISH : ST_SCAN1;
                end
            end
            ST_SCAN1: begin
                if (tail.v) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = go_reg ? ST_SCAN2 : ST_FINISH;
            end
            ST_SCAN2: begin
                if (tail.v) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Pick the slot update and whether a release check follows, from the first wave
    always_comb begin
        s_ready         = (state_reg == ST_IDLE);
        cmd_next.kind   = CMD_NONE;
        cmd_next.min_id = tail.min_id;
        go_next         = 1'b0;
        priority if (tail.hit_seen) begin
            cmd_next.kind = CMD_HIT;
            go_next       = (tail.need == '0);
        end else if ((tail.need != '0) && tail.free_seen) begin
            cmd_next.kind = CMD_FREE;
            go_next       = (tail.need == QUORUM_W'(1));
        end else if (tail.min_ok
                     && pos_less(tail.min_file, tail.min_off, req_file_reg, req_off_reg)) begin
            cmd_next.kind = CMD_MIN;
            go_next       = (tail.need == '0);
        end else begin
            cmd_next.kind = CMD_NONE;
            go_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            launch_reg     <= '0;
            cmd_reg.kind   <= CMD_NONE;
            cmd_reg.min_id <= '0;
            go_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_beat) begin
                launch_reg.v         <= (quorum != QUORUM_W'(1));
                launch_reg.first     <= 1'b1;
                launch_reg.need      <= quorum;
                launch_reg.hit_seen  <= 1'b0;
                launch_reg.free_seen <= 1'b0;
                launch_reg.min_ok    <= 1'b0;
                launch_reg.min_id    <= '0;
                launch_reg.min_file  <= '0;
                launch_reg.min_off   <= '0;
            end else if ((state_reg == ST_UPDATE) && go_reg) begin
                // Second wave only gathers the minimum
                launch_reg.v     <= 1'b1;
                launch_reg.first <= 1'b0;
                launch_reg.need  <= '0;
            end else begin
                launch_reg.v <= 1'b0;
            end
            if ((state_reg == ST_SCAN1) && tail.v) begin
                cmd_reg <= cmd_next;
                go_reg  <= go_next;
            end else if (state_reg == ST_UPDATE) begin
                cmd_reg.kind <= CMD_NONE;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            req_id_reg   <= s_replica_id;
            req_file_reg <= s_ack_file;
            req_off_reg  <= s_ack_pos;
            if (quorum == QUORUM_W'(1)) begin
                res_valid_reg <= 1'b1;
                res_file_reg  <= s_ack_file;
                res_pos_reg   <= s_ack_pos;
            end
        end
        if ((state_reg == ST_SCAN1) && tail.v) begin
            res_valid_reg  <= 1'b0;
            res_file_reg   <= '0;
            res_pos_reg    <= '0;
        end
        if ((state_reg == ST_SCAN2) && tail.v) begin
            res_valid_reg <= 1'b1;
            res_file_reg  <= tail.min_file;
            res_pos_reg   <= tail.min_off;
        end
        if (out_load) begin
            m_rel_valid_reg <= res_valid_reg;
            m_rel_file_reg  <= res_file_reg;
            m_rel_pos_reg   <= res_pos_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_release_valid = m_rel_valid_reg;
    assign m_release_file  = m_rel_file_reg;
    assign m_release_pos   = m_rel_pos_reg;

    // ---------------- checks ----------------
    `RAQT_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready,
        "second ack taken while busy")
    `RAQT_ASSERT_NOW(a_no_release_zero, m_valid && !m_release_valid,
        m_release_file == '0 && m_release_pos == '0, "non-release carries payload")
    `RAQT_ASSERT_NOW(a_wave_in_scan, tail.v,
        state_reg == ST_SCAN1 || state_reg == ST_SCAN2, "wave left chain outside a scan")
    `RAQT_ASSERT_NOW(a_cmd_in_update, cmd_reg.kind != CMD_NONE, state_reg == ST_UPDATE,
        "slot write outside update")

endmodule
